>>> rtl/core/ssgs_pkg.sv
`default_nettype none

package ssgs_pkg;

   // Beat kinds on the request channel (tuser)
   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_WRITE = 1'b1
   } command_type;

   localparam int STEP_COUNT_DEF = 16;
   localparam int STEP_W         = 4;
   localparam int MARK_W         = 16;
   localparam int ROW_W          = 14;
   localparam int MV_W           = 15;
   localparam int PHASE_W        = 33;
   localparam int KNOB_W         = 5;

   localparam logic [KNOB_W-1:0]  KNOB_RESET      = 5'd16;
   localparam logic [ROW_W-1:0]   ROW_MAX_MV      = 14'd10000;
   localparam logic [ROW_W-1:0]   ROW1_RESET_MV   = 14'd1000;
   localparam logic [PHASE_W-1:0] HALF_CYCLE      = 33'h0_8000_0000;
   localparam logic signed [15:0] SCHMITT_HIGH_MV = 16'sd1000;

   // Request tdata layout
   localparam int REQ_DATA_W = 120;
   localparam int IN_EXT_CONN = 0;
   localparam int IN_EXT_MV   = 1;
   localparam int IN_RUN_BTN  = 16;
   localparam int IN_RST_BTN  = 17;
   localparam int IN_RST_MV   = 18;
   localparam int IN_CV_MV    = 33;
   localparam int IN_GATE_BTN = 48;
   localparam int IN_PHASE    = 64;
   localparam int IN_ROW_SEL  = 97;
   localparam int IN_STEP_SEL = 99;
   localparam int IN_VALUE    = 103;

   // Response tdata layout
   localparam int RSP_DATA_W     = 88;
   localparam int OUT_ROW1       = 0;
   localparam int OUT_ROW2       = 14;
   localparam int OUT_ROW3       = 28;
   localparam int OUT_GATES      = 42;
   localparam int OUT_STEP_GATES = 43;
   localparam int OUT_STEP       = 59;
   localparam int OUT_RUNNING    = 63;
   localparam int OUT_PHASE      = 64;
   localparam int OUT_MARKS      = 65;
   localparam int OUT_USED_W     = 81;

endpackage

`default_nettype wire

>>> rtl/core/sixteen_step_gate_sequencer.sv
`default_nettype none

// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  req_tdata[119:0], req_tuser[0]
// rsp       out  rsp_tvalid/rsp_tready  rsp_tdata[87:0]
// csr       in   csr_valid/csr_ready    csr_data[4:0] (steps knob)
//
// One beat per cycle: all step logic sits between the state registers and the
// response register, so a request beat is taken every cycle the response
// register is empty or being drained. A tick's response is registered and
// valid in the cycle after acceptance; a row write returns nothing. Reset is
// synchronous and restores running, step 0, all marks set, default row values.

module sixteen_step_gate_sequencer
   import ssgs_pkg::*;
#(
   parameter int STEP_COUNT = STEP_COUNT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // ext_clock_connected, ext_clock_mv, run_button, reset_button, reset_mv,
   // steps_cv_mv, gate_buttons, phase_increment, row_select, step_select,
   // step_value, zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  wire logic [0:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // row1_mv, row2_mv, row3_mv, gates_out, step_gates, current_step,
   // running_flag, gate_phase, gate_marks_out, zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [KNOB_W-1:0]     csr_data
);

   localparam int IDX_W = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
   localparam logic [MARK_W-1:0] STEP_MASK = MARK_W'((17'd1 << STEP_COUNT) - 17'd1);

   // request fields
   command_type              cmd;
   logic                     ext_conn;
   logic signed [MV_W-1:0]   ext_mv;
   logic                     run_btn;
   logic                     rst_btn;
   logic signed [MV_W-1:0]   rst_mv;
   logic signed [MV_W-1:0]   cv_mv;
   logic [MARK_W-1:0]        gate_btn;
   logic [PHASE_W-1:0]       phase_inc;
   logic [1:0]               row_sel;
   logic [STEP_W-1:0]        step_sel;
   logic [ROW_W-1:0]         step_value;

   assign cmd        = command_type'(req_tuser[0]);
   assign ext_conn   = req_tdata[IN_EXT_CONN];
   assign ext_mv     = req_tdata[IN_EXT_MV +: MV_W];
   assign run_btn    = req_tdata[IN_RUN_BTN];
   assign rst_btn    = req_tdata[IN_RST_BTN];
   assign rst_mv     = req_tdata[IN_RST_MV +: MV_W];
   assign cv_mv      = req_tdata[IN_CV_MV +: MV_W];
   assign gate_btn   = req_tdata[IN_GATE_BTN +: MARK_W];
   assign phase_inc  = req_tdata[IN_PHASE +: PHASE_W];
   assign row_sel    = req_tdata[IN_ROW_SEL +: 2];
   assign step_sel   = req_tdata[IN_STEP_SEL +: STEP_W];
   assign step_value = req_tdata[IN_VALUE +: ROW_W];

   // state
   logic [KNOB_W-1:0]   knob_ff;
   logic                running_ff, running_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [MARK_W-1:0]   marks_ff, marks_in;
   logic                clk_trig_ff, clk_trig_in;
   logic                run_trig_ff;
   logic                rst_trig_ff, rst_trig_in;
   logic [MARK_W-1:0]   gate_trig_ff;
   logic [ROW_W-1:0]    row1_ff [STEP_COUNT];
   logic [ROW_W-1:0]    row2_ff [STEP_COUNT];
   logic [ROW_W-1:0]    row3_ff [STEP_COUNT];
   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 req_fire;
   logic                 tick_fire;
   logic                 write_fire;

   // step logic
   logic [PHASE_W:0]     phase_sum;
   logic [PHASE_W-1:0]   phase_adv;
   logic                 advance;
   logic [STEP_W:0]      step_plus;
   logic [14:0]          knob_mv;
   logic signed [17:0]   steps_mv;
   logic signed [17:0]   wrap_mv;
   logic                 wrap;
   logic signed [15:0]   rst_level;
   logic                 gate_phase;
   logic                 mark;
   logic                 gates_out;
   logic [MARK_W-1:0]    step_gates;
   logic [IDX_W-1:0]     rd_idx;
   logic [IDX_W-1:0]     wr_idx;
   logic [ROW_W-1:0]     wr_value;
   logic                 wr_ok;

   function automatic logic signed [15:0] ext_sum_btn(input logic btn);
      ext_sum_btn = btn ? SCHMITT_HIGH_MV : 16'sd0;
   endfunction

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;
   assign tick_fire  = req_fire & (cmd == CMD_TICK);
   assign write_fire = req_fire & (cmd == CMD_WRITE);
   assign csr_ready  = 1'b1;

   // Wrap when step+1 reaches round(knob + cv/1000) clamped to 1..STEP_COUNT:
   // idx >= round(s/1000) is the same as idx*1000 + 500 > s.
   assign step_plus = {1'b0, step_ff} + (STEP_W+1)'(1);
   assign knob_mv   = 15'(knob_ff) * 15'd1000;
   assign steps_mv  = $signed({3'b000, knob_mv}) + 18'(cv_mv);
   assign wrap_mv   = $signed({3'b000, 15'(step_plus) * 15'd1000 + 15'd500});
   assign wrap      = (step_plus >= (STEP_W+1)'(STEP_COUNT)) || (wrap_mv > steps_mv);

   assign phase_sum = {1'b0, phase_ff} + {1'b0, phase_inc};
   assign rst_level = 16'(ext_sum_btn(rst_btn)) + 16'(rst_mv);

   always_comb begin
      running_in  = running_ff ^ (run_btn & ~run_trig_ff);
      clk_trig_in = clk_trig_ff;
      advance     = 1'b0;
      phase_adv   = phase_ff;
      gate_phase  = 1'b0;

      if (running_in) begin
         if (ext_conn) begin
            if (clk_trig_ff) begin
               if (ext_mv <= 0) begin
                  clk_trig_in = 1'b0;
               end
            end else if (16'(ext_mv) >= SCHMITT_HIGH_MV) begin
               clk_trig_in = 1'b1;
               advance     = 1'b1;
            end
         end else begin
            phase_adv = phase_sum[PHASE_W-1:0];
            advance   = phase_sum[PHASE_W] | phase_sum[PHASE_W-1];
         end
      end

      phase_in = phase_adv;
      step_in  = step_ff;
      if (advance) begin
         phase_in = '0;
         step_in  = wrap ? '0 : step_plus[STEP_W-1:0];
      end

      // gate phase is taken before the reset jump
      if (running_in) begin
         gate_phase = ext_conn ? clk_trig_in : (phase_in < HALF_CYCLE);
      end

      rst_trig_in = rst_trig_ff;
      if (rst_trig_ff) begin
         if (rst_level <= 0) begin
            rst_trig_in = 1'b0;
         end
      end else if (rst_level >= SCHMITT_HIGH_MV) begin
         rst_trig_in = 1'b1;
         phase_in    = '0;
         step_in     = '0;
      end

      marks_in   = (marks_ff ^ (gate_btn & ~gate_trig_ff)) & STEP_MASK;
      mark       = marks_in[step_in];
      gates_out  = gate_phase & mark;
      step_gates = gates_out ? (MARK_W'(1) << step_in) : '0;
      rd_idx     = step_in[IDX_W-1:0];

      rsp_data_in = '0;
      rsp_data_in[OUT_ROW1 +: ROW_W]        = row1_ff[rd_idx];
      rsp_data_in[OUT_ROW2 +: ROW_W]        = row2_ff[rd_idx];
      rsp_data_in[OUT_ROW3 +: ROW_W]        = row3_ff[rd_idx];
      rsp_data_in[OUT_GATES]                = gates_out;
      rsp_data_in[OUT_STEP_GATES +: MARK_W] = step_gates;
      rsp_data_in[OUT_STEP +: STEP_W]       = step_in;
      rsp_data_in[OUT_RUNNING]              = running_in;
      rsp_data_in[OUT_PHASE]                = gate_phase;
      rsp_data_in[OUT_MARKS +: MARK_W]      = marks_in;
   end

   assign wr_ok    = (row_sel != 2'd3) &&
                     ({1'b0, step_sel} < (STEP_W+1)'(STEP_COUNT));
   assign wr_idx   = step_sel[IDX_W-1:0];
   assign wr_value = (step_value > ROW_MAX_MV) ? ROW_MAX_MV : step_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         knob_ff      <= KNOB_RESET;
         running_ff   <= 1'b1;
         phase_ff     <= '0;
         step_ff      <= '0;
         marks_ff     <= STEP_MASK;
         clk_trig_ff  <= 1'b0;
         run_trig_ff  <= 1'b0;
         rst_trig_ff  <= 1'b0;
         gate_trig_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STEP_COUNT; i++) begin
            row1_ff[i] <= ROW1_RESET_MV;
            row2_ff[i] <= '0;
            row3_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            knob_ff <= csr_data;
         end
         if (tick_fire) begin
            running_ff   <= running_in;
            phase_ff     <= phase_in;
            step_ff      <= step_in;
            marks_ff     <= marks_in;
            clk_trig_ff  <= clk_trig_in;
            run_trig_ff  <= run_btn;
            rst_trig_ff  <= rst_trig_in;
            gate_trig_ff <= gate_btn;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (write_fire && wr_ok) begin
            case (row_sel)
               2'd0: begin
                  row1_ff[wr_idx] <= wr_value;
               end
               2'd1: begin
                  row2_ff[wr_idx] <= wr_value;
               end
               2'd2: begin
                  row3_ff[wr_idx] <= wr_value;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/ssgs_checker.sv
`default_nettype none

module ssgs_checker
   import ssgs_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   input wire logic [0:0]            req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  csr_valid,
   input wire logic                  csr_ready,
   input wire logic [KNOB_W-1:0]     csr_data
);

   logic write_beat;
   assign write_beat = req_tvalid & req_tready & (req_tuser[0] == CMD_WRITE);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // a row write never produces a response beat
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      write_beat && (!rsp_tvalid || rsp_tready) |=> !rsp_tvalid)
      else $error("row write produced a response");

   // at most one step gate, and it agrees with the summed gate
   a_step_gates: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[OUT_STEP_GATES +: MARK_W]) &&
      (rsp_tdata[OUT_GATES] == |rsp_tdata[OUT_STEP_GATES +: MARK_W]))
      else $error("step gates inconsistent");

   // gate phase only while running
   a_phase_running: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[OUT_PHASE] |-> rsp_tdata[OUT_RUNNING])
      else $error("gate phase high while stopped");

endmodule

bind sixteen_step_gate_sequencer ssgs_checker u_ssgs_checker (.*);

`default_nettype wire

>>> sim/sixteen_step_gate_sequencer_test.sv
module sixteen_step_gate_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ssgs_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_ITEMS    = 205;

   typedef struct {
      command_type             cmd;
      bit                      ext_conn;
      logic signed [MV_W-1:0]  ext_mv;
      bit                      run_btn;
      bit                      rst_btn;
      logic signed [MV_W-1:0]  rst_mv;
      logic signed [MV_W-1:0]  cv_mv;
      logic [MARK_W-1:0]       gate_btn;
      logic [PHASE_W-1:0]      phase_inc;
      logic [1:0]              row_sel;
      logic [STEP_W-1:0]       step_sel;
      logic [ROW_W-1:0]        value;
   } seq_req_type;

   typedef struct {
      logic [ROW_W-1:0]  row1;
      logic [ROW_W-1:0]  row2;
      logic [ROW_W-1:0]  row3;
      bit                gates;
      logic [MARK_W-1:0] step_gates;
      logic [STEP_W-1:0] step;
      bit                running;
      bit                gate_phase;
      logic [MARK_W-1:0] marks;
   } step_report_type;

   class step_sequencer_board;
      int                 errors;
      int                 knob;
      bit                 running;
      logic [PHASE_W-1:0] phase;
      int                 step;
      logic [MARK_W-1:0]  marks;
      logic [ROW_W-1:0]   rows[3][STEP_COUNT_DEF];
      bit                 clk_trig;
      bit                 run_trig;
      bit                 rst_trig;
      logic [MARK_W-1:0]  gate_trig;
      step_report_type    pending_step_reports[$];

      function new();
         errors = 0;
         knob = int'(KNOB_RESET);
         running = 1;
         phase = '0;
         step = 0;
         marks = '1;
         for (int i = 0; i < STEP_COUNT_DEF; i++) begin
            rows[0][i] = ROW1_RESET_MV;
            rows[1][i] = '0;
            rows[2][i] = '0;
         end
         clk_trig = 0;
         run_trig = 0;
         rst_trig = 0;
         gate_trig = '0;
      endfunction

      function void set_knob(int v);
         knob = v;
      endfunction

      function int pending();
         return pending_step_reports.size();
      endfunction

      // Schmitt trigger: rise at >= 1000 mV, fall at <= 0 mV
      function bit fire(inout bit hi, input int mv);
         if (hi) begin
            if (mv <= 0) hi = 0;
            return 0;
         end
         if (mv >= int'(SCHMITT_HIGH_MV)) begin
            hi = 1;
            return 1;
         end
         return 0;
      endfunction

      function int step_limit(int cv);
         int s;
         int n;
         s = knob * 1000 + cv;
         if (s >= 0) n = (s + 500) / 1000;
         else n = -((-s + 500) / 1000);
         if (n < 1) n = 1;
         if (n > STEP_COUNT_DEF) n = STEP_COUNT_DEF;
         return n;
      endfunction

      function void jump_to(int idx, int cv);
         phase = '0;
         step = (idx >= step_limit(cv)) ? 0 : idx;
      endfunction

      function void take_request(seq_req_type r);
         int               cv;
         int               ext;
         int               rst_level;
         bit               gate_in;
         bit               hi;
         bit               mark;
         logic [PHASE_W:0] sum;
         logic [ROW_W-1:0] v;
         step_report_type  rep;
         cv = int'(r.cv_mv);
         ext = int'(r.ext_mv);
         if (r.cmd == CMD_WRITE) begin
            v = (r.value > ROW_MAX_MV) ? ROW_MAX_MV : r.value;
            if (r.row_sel != 2'd3 && r.step_sel < STEP_COUNT_DEF)
               rows[r.row_sel][r.step_sel] = v;
            return;
         end
         if (fire(run_trig, r.run_btn ? 1000 : 0)) running = !running;
         gate_in = 0;
         if (running) begin
            if (r.ext_conn) begin
               if (fire(clk_trig, ext)) jump_to(step + 1, cv);
               gate_in = clk_trig;
            end else begin
               sum = {1'b0, phase} + {1'b0, r.phase_inc};
               phase = sum[PHASE_W-1:0];
               // overflow past one full cycle (2^32) at full width
               if (sum[PHASE_W:PHASE_W-1] != 2'b00) jump_to(step + 1, cv);
               gate_in = (phase < HALF_CYCLE);
            end
         end
         rst_level = (r.rst_btn ? 1000 : 0) + int'(r.rst_mv);
         if (fire(rst_trig, rst_level)) jump_to(0, cv);
         for (int i = 0; i < STEP_COUNT_DEF; i++) begin
            hi = gate_trig[i];
            if (fire(hi, r.gate_btn[i] ? 1000 : 0)) marks[i] = !marks[i];
            gate_trig[i] = hi;
         end
         mark = marks[step];
         rep.row1 = rows[0][step];
         rep.row2 = rows[1][step];
         rep.row3 = rows[2][step];
         rep.gates = gate_in && mark;
         rep.step_gates = (running && gate_in && mark) ? (16'd1 << step) : 16'd0;
         rep.step = STEP_W'(step);
         rep.running = running;
         rep.gate_phase = gate_in;
         rep.marks = marks;
         pending_step_reports.push_back(rep);
      endfunction

      function void compare(string field, logic [PHASE_W-1:0] want, logic [PHASE_W-1:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
         end
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] d);
         step_report_type want;
         if (pending_step_reports.size() == 0) begin
            errors++;
            $display("%0t: response beat with nothing expected, expected none got %h",
                     $time, d);
            return;
         end
         want = pending_step_reports.pop_front();
         compare("row1_mv", want.row1, d[OUT_ROW1 +: ROW_W]);
         compare("row2_mv", want.row2, d[OUT_ROW2 +: ROW_W]);
         compare("row3_mv", want.row3, d[OUT_ROW3 +: ROW_W]);
         compare("gates_out", want.gates, d[OUT_GATES]);
         compare("step_gates", want.step_gates, d[OUT_STEP_GATES +: MARK_W]);
         compare("current_step", want.step, d[OUT_STEP +: STEP_W]);
         compare("running_flag", want.running, d[OUT_RUNNING]);
         compare("gate_phase", want.gate_phase, d[OUT_PHASE]);
         compare("gate_marks_out", want.marks, d[OUT_MARKS +: MARK_W]);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [KNOB_W-1:0]     csr_data = '0;

   step_sequencer_board board = new();

   logic [15:0]       stall_pattern = '1;
   logic [3:0]        stall_pos = '0;
   bit                stall_free = 1;
   bit                ext_sel = 0;
   bit                run_level = 0;
   logic [MARK_W-1:0] gate_level = '0;
   int                idle_cycles = 0;

   sixteen_step_gate_sequencer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      stall_pos <= stall_pos + 4'd1;
      rsp_tready <= stall_free || stall_pattern[stall_pos];
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("sixteen_step_gate_sequencer_test: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic seq_req_type tick_base();
      seq_req_type r;
      r.cmd = CMD_TICK;
      r.ext_conn = 0;
      r.ext_mv = '0;
      r.run_btn = 0;
      r.rst_btn = 0;
      r.rst_mv = '0;
      r.cv_mv = '0;
      r.gate_btn = '0;
      r.phase_inc = '0;
      r.row_sel = '0;
      r.step_sel = '0;
      r.value = '0;
      return r;
   endfunction

   function automatic seq_req_type write_beat(int row, int st, int v);
      seq_req_type r;
      r = tick_base();
      r.cmd = CMD_WRITE;
      r.row_sel = 2'(row);
      r.step_sel = STEP_W'(st);
      r.value = ROW_W'(v);
      return r;
   endfunction

   function automatic seq_req_type random_beat();
      seq_req_type r;
      int          k;
      int          tmp;
      logic [63:0] wide;
      r = tick_base();
      r.row_sel = 2'($urandom());
      r.step_sel = 4'($urandom());
      r.value = 14'($urandom());
      if ($urandom_range(0, 7) == 0) begin
         r.cmd = CMD_WRITE;
         if ($urandom_range(0, 3) != 0) r.value = ROW_W'($urandom_range(0, 10000));
         r.ext_mv = 15'($urandom());
         r.phase_inc = 33'($urandom());
         return r;
      end
      if ($urandom_range(0, 99) == 0) ext_sel = !ext_sel;
      if ($urandom_range(0, 59) == 0) run_level = !run_level;
      r.ext_conn = ($urandom_range(0, 29) == 0) ? !ext_sel : ext_sel;
      r.run_btn = run_level;

      // external clock swings between the Schmitt bands most of the time
      k = $urandom_range(0, 9);
      if (k < 4) r.ext_mv = MV_W'($urandom_range(1000, 16383));
      else if (k < 8) begin
         tmp = $urandom_range(0, 16384);
         r.ext_mv = MV_W'(-tmp);
      end else if (k == 8) r.ext_mv = MV_W'($urandom_range(1, 999));
      else r.ext_mv = 15'($urandom());

      k = $urandom_range(0, 39);
      if (k == 0) begin
         r.rst_btn = 1;
         tmp = $urandom_range(0, 3000);
         r.rst_mv = MV_W'(tmp - 1500);
      end else if (k == 1) begin
         r.rst_btn = 1'($urandom_range(0, 1));
         r.rst_mv = 15'($urandom());
      end else begin
         tmp = $urandom_range(0, 400);
         r.rst_mv = MV_W'(-tmp);
      end

      k = $urandom_range(0, 7);
      if (k < 4) r.cv_mv = '0;
      else if (k < 6) begin
         tmp = $urandom_range(0, 8000);
         r.cv_mv = MV_W'(tmp - 4000);
      end else if (k == 6) begin
         tmp = $urandom_range(0, 64);
         r.cv_mv = MV_W'((tmp - 32) * 500);
      end else r.cv_mv = 15'($urandom());

      if ($urandom_range(0, 5) == 0) gate_level[$urandom_range(0, 15)] ^= 1'b1;
      if ($urandom_range(0, 79) == 0) gate_level = 16'($urandom());
      r.gate_btn = gate_level;

      k = $urandom_range(0, 9);
      wide = {$urandom(), $urandom()};
      if (k < 5) r.phase_inc = PHASE_W'($urandom_range(32'h4000_0000, 32'hC000_0000));
      else if (k < 7) r.phase_inc = PHASE_W'($urandom_range(0, 32'h1000_0000));
      else if (k == 7) r.phase_inc = wide[PHASE_W-1:0];
      else if (k == 8) begin
         case ($urandom_range(0, 4))
            0: r.phase_inc = 33'h0_0000_0000;
            1: r.phase_inc = 33'h0_8000_0000;
            2: r.phase_inc = 33'h1_0000_0000;
            3: r.phase_inc = 33'h0_FFFF_FFFF;
            default: r.phase_inc = 33'h1_FFFF_FFFF;
         endcase
      end else r.phase_inc = {1'b1, wide[31:0]};
      return r;
   endfunction

   // call at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_beat(seq_req_type r);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[IN_EXT_CONN] = r.ext_conn;
      d[IN_EXT_MV +: MV_W] = r.ext_mv;
      d[IN_RUN_BTN] = r.run_btn;
      d[IN_RST_BTN] = r.rst_btn;
      d[IN_RST_MV +: MV_W] = r.rst_mv;
      d[IN_CV_MV +: MV_W] = r.cv_mv;
      d[IN_GATE_BTN +: MARK_W] = r.gate_btn;
      d[IN_PHASE +: PHASE_W] = r.phase_inc;
      d[IN_ROW_SEL +: 2] = r.row_sel;
      d[IN_STEP_SEL +: STEP_W] = r.step_sel;
      d[IN_VALUE +: ROW_W] = r.value;
      req_tvalid <= 1'b1;
      req_tuser <= r.cmd;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_request(r);
      @(negedge clock);
   endtask

   // knob writes only once the block has drained
   task automatic start_phase(int knob, bit busy);
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= KNOB_W'(knob);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_knob(knob);
      stall_free = !busy;
      stall_pattern = 16'($urandom()) | 16'd1;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(int n_items, bit busy);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < n_items; k++) begin
            send_beat(random_beat());
            sent++;
         end
         gap = busy ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      seq_req_type r;
      int          knobs[8];
      bit          busy[8];
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      start_phase(16, 0);
      send_beat(tick_base());
      send_beat(write_beat(0, 0, 16383));   // clamps to 10000
      send_beat(write_beat(1, 1, 2500));
      send_beat(write_beat(2, 15, 10000));
      send_beat(write_beat(3, 2, 1234));    // row select 3: dropped
      send_beat(write_beat(0, 1, 9999));
      r = tick_base();
      r.phase_inc = 33'h1_0000_0000;        // exactly one cycle
      send_beat(r);
      r.phase_inc = HALF_CYCLE;             // gate phase just off
      send_beat(r);
      r.phase_inc = 33'h0_7FFF_FFFF;        // one short of a wrap
      send_beat(r);
      r.phase_inc = 33'h1_FFFF_FFFF;
      send_beat(r);
      r = tick_base();
      r.ext_conn = 1;
      r.ext_mv = MV_W'(999);
      send_beat(r);
      r.ext_mv = MV_W'(1000);
      send_beat(r);
      r.ext_mv = MV_W'(1);
      send_beat(r);
      r.ext_mv = MV_W'(0);
      send_beat(r);
      r.ext_mv = MV_W'(16383);
      send_beat(r);
      r.ext_mv = MV_W'(-16384);
      send_beat(r);
      // stop, clock edge while stopped, then restart
      r.run_btn = 1;
      send_beat(r);
      r.ext_mv = MV_W'(16383);
      send_beat(r);
      r.run_btn = 0;
      send_beat(r);
      r.run_btn = 1;
      send_beat(r);
      r = tick_base();
      r.rst_mv = MV_W'(1000);
      send_beat(r);
      r.rst_btn = 1;
      r.rst_mv = MV_W'(-1000);              // sum of zero drops the trigger
      send_beat(r);
      r.rst_mv = MV_W'(0);
      send_beat(r);
      r = tick_base();
      r.phase_inc = 33'h1_0000_0000;
      r.cv_mv = MV_W'(-500);                // 15.5 rounds to 16
      send_beat(r);
      r.cv_mv = MV_W'(-15500);
      send_beat(r);
      r.cv_mv = MV_W'(-16384);
      send_beat(r);
      r.cv_mv = MV_W'(16383);
      r.gate_btn = 16'hFFFF;
      send_beat(r);
      r.gate_btn = 16'h0000;
      send_beat(r);
      r.gate_btn = 16'h8001;
      send_beat(r);
      req_tvalid <= 1'b0;

      knobs = '{16, 1, 31, 0, $urandom_range(2, 15), 16, $urandom_range(1, 16), 3};
      busy = '{0, 1, 1, 1, 1, 0, 1, 1};
      for (int p = 0; p < 8; p++) begin
         start_phase(knobs[p], busy[p]);
         run_phase(PHASE_ITEMS, busy[p]);
      end

      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.errors == 0) begin
         $display("sixteen_step_gate_sequencer_test: done, clean");
      end else begin
         $display("sixteen_step_gate_sequencer_test: done, errors");
      end
      $finish;
   end

endmodule
